>>> hw/rtl/qte_pkg.sv
// Shared constants, record types and tables for the quaternion to Euler angle core.
package qte_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int SQRT_STEPS    = 31;
    localparam int NORM_STEPS    = 6;
    localparam int ATAN_LAT      = 1 + NORM_STEPS + 1 + CORDIC_STAGES;
    localparam int PIPE_LAT      = 4 + SQRT_STEPS + ATAN_LAT;

    localparam logic signed [63:0] ONE_Q58 = 64'sd1 <<< 58;
    localparam logic [31:0] QUARTER_POS = 32'h4000_0000;
    localparam logic [31:0] QUARTER_NEG = 32'hC000_0000;
    localparam logic [31:0] ROUND_HALF  = 32'd1 << (31 - ANGLE_BITS);

    typedef struct packed {
        logic signed [63:0] ww, xx, zz, xy, wz, xz, wy, yz, wx;
    } t_prod;

    typedef struct packed {
        logic signed [63:0] yaw_y, yaw_x, s, roll_y, roll_x;
    } t_sum;

    typedef struct packed {
        logic signed [31:0] s30;
        logic signed [63:0] yaw_y, yaw_x, roll_y, roll_x;
    } t_clamp;

    typedef struct packed {
        logic [63:0]        v;
        logic [63:0]        res;
        logic signed [31:0] s30;
        logic signed [63:0] yaw_y, yaw_x, roll_y, roll_x;
    } t_sq_stage;

    typedef struct packed {
        logic signed [63:0] x, y;
        logic [63:0]        m;
        logic               zero;
    } t_norm;

    typedef struct packed {
        logic signed [33:0] x, y;
        logic [31:0]        z;
        logic               zero;
    } t_cordic;

    // atan(2^-i) in units of 2^-32 of a full turn
    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

    // Round a full-turn angle to nearest, ties up, wrapping, into the 16-bit field.
    function automatic logic [15:0] to_field(input logic [31:0] a);
        logic [31:0] r;
        r = (a + ROUND_HALF) >> (32 - ANGLE_BITS);
        return r[15:0];
    endfunction

endpackage

>>> hw/rtl/quaternion_to_euler_core.sv
// Top level of the quaternion to Euler angle core.
//
// The slave stream carries one attitude quaternion per beat, four signed Q30
// components packed w, x, y, z from the low bits up. The master stream returns
// one beat per quaternion with yaw, pitch and roll as 16-bit binary angles
// (32768 stands for pi), yaw in the low bits.
//
// The block is a fixed pipeline: products, sums, arcsine argument clamp,
// square, a row of 31 square root cells, then three parallel atan2 units
// (magnitude, six normalization shifts, quadrant fold, a row of CORDIC cells),
// and one output register. A new beat is taken in every cycle unless the output
// stalls; the throughput is then one beat per cycle.
//
// Reset clears all valid bits; the pipeline holds no other state. When the
// receiver stalls with a result waiting, the whole pipeline freezes and
// o_s_tready drops in the same cycle, so no beat is lost. Results leave in
// the order their quaternions arrived.
module quaternion_to_euler_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [47:0]  o_m_tdata    // yaw_angle, pitch_angle, roll_angle
);
    logic en;

    logic signed [31:0] qw, qx, qy, qz;
    assign qw = i_s_tdata[31:0];
    assign qx = i_s_tdata[63:32];
    assign qy = i_s_tdata[95:64];
    assign qz = i_s_tdata[127:96];

    logic [qte_pkg::PIPE_LAT-1:0] r_vld;
    logic                         r_out_vld;
    logic [47:0]                  r_out_data;

    qte_pkg::t_prod     r_prod;
    qte_pkg::t_sum      r_sum;
    qte_pkg::t_clamp    r_clamp;
    qte_pkg::t_sq_stage r_sq;
    qte_pkg::t_sq_stage sq_chain [0:qte_pkg::SQRT_STEPS];

    logic signed [63:0] s_cl;
    logic [31:0]        yaw_a, pitch_a, roll_a;

    // The pipeline advances whenever the output register is free or being taken.
    assign en         = !r_out_vld || i_m_tready;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[qte_pkg::PIPE_LAT-2:0], i_s_tvalid};
            r_out_vld <= r_vld[qte_pkg::PIPE_LAT-1];
        end
    end

    // Stage 1: all nine component products, exact in Q60.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod.ww <= qw * qw;
            r_prod.xx <= qx * qx;
            r_prod.zz <= qz * qz;
            r_prod.xy <= qx * qy;
            r_prod.wz <= qw * qz;
            r_prod.xz <= qx * qz;
            r_prod.wy <= qw * qy;
            r_prod.yz <= qy * qz;
            r_prod.wx <= qw * qx;
        end
    end

    // Stage 2: drop to Q58 and form the doubled sums and differences.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum.yaw_y  <= ((r_prod.xy >>> 2) - (r_prod.wz >>> 2)) <<< 1;
            r_sum.yaw_x  <= (((r_prod.ww >>> 2) + (r_prod.xx >>> 2)) <<< 1) - qte_pkg::ONE_Q58;
            r_sum.s      <= ((r_prod.xz >>> 2) + (r_prod.wy >>> 2)) <<< 1;
            r_sum.roll_y <= ((r_prod.yz >>> 2) - (r_prod.wx >>> 2)) <<< 1;
            r_sum.roll_x <= (((r_prod.ww >>> 2) + (r_prod.zz >>> 2)) <<< 1) - qte_pkg::ONE_Q58;
        end
    end

    // Stage 3: clamp the arcsine argument to plus or minus one and take it to Q30.
    always_comb begin
        s_cl = r_sum.s;
        if (r_sum.s > qte_pkg::ONE_Q58) begin
            s_cl = qte_pkg::ONE_Q58;
        end
        if (r_sum.s < -qte_pkg::ONE_Q58) begin
            s_cl = -qte_pkg::ONE_Q58;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_clamp.s30    <= 32'(s_cl >>> 28);
            r_clamp.yaw_y  <= r_sum.yaw_y;
            r_clamp.yaw_x  <= r_sum.yaw_x;
            r_clamp.roll_y <= r_sum.roll_y;
            r_clamp.roll_x <= r_sum.roll_x;
        end
    end

    // Stage 4: radicand 2^60 - s^2 for the cosine of the pitch.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq.v      <= (64'd1 << 60) - 64'(r_clamp.s30) * 64'(r_clamp.s30);
            r_sq.res    <= 64'd0;
            r_sq.s30    <= r_clamp.s30;
            r_sq.yaw_y  <= r_clamp.yaw_y;
            r_sq.yaw_x  <= r_clamp.yaw_x;
            r_sq.roll_y <= r_clamp.roll_y;
            r_sq.roll_x <= r_clamp.roll_x;
        end
    end

    assign sq_chain[0] = r_sq;

    // Square root cells; yaw and roll operands ride along to stay aligned.
    for (genvar i = 0; i < qte_pkg::SQRT_STEPS; i++) begin : g_sqrt
        qte_sqrt_cell u_sqrt (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_step (5'(i)),
            .i_d    (sq_chain[i]),
            .o_d    (sq_chain[i+1])
        );
    end

    qte_atan2 u_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (sq_chain[qte_pkg::SQRT_STEPS].yaw_y),
        .i_x     (sq_chain[qte_pkg::SQRT_STEPS].yaw_x),
        .o_angle (yaw_a)
    );

    qte_atan2 u_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (-64'(sq_chain[qte_pkg::SQRT_STEPS].s30)),
        .i_x     (sq_chain[qte_pkg::SQRT_STEPS].res),
        .o_angle (pitch_a)
    );

    qte_atan2 u_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (sq_chain[qte_pkg::SQRT_STEPS].roll_y),
        .i_x     (sq_chain[qte_pkg::SQRT_STEPS].roll_x),
        .o_angle (roll_a)
    );

    // Output register: rounding into the binary angle fields.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= {qte_pkg::to_field(roll_a), qte_pkg::to_field(pitch_a),
                           qte_pkg::to_field(yaw_a)};
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while output is stalled");

    a_free_output_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input refused while the output register is empty");

    a_valid_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_tready && r_vld[qte_pkg::PIPE_LAT-1]) |=> o_m_tvalid)
        else $error("finished beat did not reach the output");
endmodule

>>> hw/rtl/qte_sqrt_cell.sv
// One restoring square root step: decides one result bit and hands the rest on.
module qte_sqrt_cell (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [4:0]             i_step,
    input  qte_pkg::t_sq_stage     i_d,
    output qte_pkg::t_sq_stage     o_d
);
    logic [63:0]        bitv;
    qte_pkg::t_sq_stage n_d;
    qte_pkg::t_sq_stage r_d;

    always_comb begin
        bitv = 64'd1 << (7'd60 - {1'b0, i_step, 1'b0});
        n_d  = i_d;
        if (i_d.v >= i_d.res + bitv) begin
            n_d.v   = i_d.v - (i_d.res + bitv);
            n_d.res = (i_d.res >> 1) + bitv;
        end else begin
            n_d.res = i_d.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

>>> hw/rtl/qte_cordic_cell.sv
// One vectoring CORDIC micro-rotation with its angle table entry.
module qte_cordic_cell (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [4:0]          i_step,
    input  qte_pkg::t_cordic    i_d,
    output qte_pkg::t_cordic    o_d
);
    logic signed [33:0] dx, dy;
    qte_pkg::t_cordic   n_d;
    qte_pkg::t_cordic   r_d;

    always_comb begin
        dx  = i_d.y >>> i_step;
        dy  = i_d.x >>> i_step;
        n_d = i_d;
        if (i_d.y > 34'sd0) begin
            n_d.x = i_d.x + dx;
            n_d.y = i_d.y - dy;
            n_d.z = i_d.z + qte_pkg::atan_lut(i_step);
        end else begin
            n_d.x = i_d.x - dx;
            n_d.y = i_d.y + dy;
            n_d.z = i_d.z - qte_pkg::atan_lut(i_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

>>> hw/rtl/qte_atan2.sv
// Pipelined atan2: magnitude, shift normalization, quadrant fold and a CORDIC cell row.
module qte_atan2 (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_y,
    input  logic signed [63:0] i_x,
    output logic [31:0]        o_angle
);
    logic [63:0]      mx, my;
    qte_pkg::t_norm   r_norm [0:qte_pkg::NORM_STEPS];
    qte_pkg::t_cordic r_rot;
    qte_pkg::t_cordic n_rot;
    qte_pkg::t_cordic chain [0:qte_pkg::CORDIC_STAGES];

    assign mx = i_x[63] ? 64'd0 - 64'(i_x) : 64'(i_x);
    assign my = i_y[63] ? 64'd0 - 64'(i_y) : 64'(i_y);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_norm[0].x    <= i_x;
            r_norm[0].y    <= i_y;
            r_norm[0].m    <= (mx > my) ? mx : my;
            r_norm[0].zero <= (i_x == 64'sd0) && (i_y == 64'sd0);
        end
    end

    // Greedy shift by 32, 16, ... 1 until the larger magnitude is below 2^29.
    for (genvar k = 0; k < qte_pkg::NORM_STEPS; k++) begin : g_norm
        localparam int SH = 32 >> k;
        logic big;
        assign big = r_norm[k].m >= (64'd1 << (28 + SH));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_norm[k+1].x    <= big ? (r_norm[k].x >>> SH) : r_norm[k].x;
                r_norm[k+1].y    <= big ? (r_norm[k].y >>> SH) : r_norm[k].y;
                r_norm[k+1].m    <= big ? (r_norm[k].m >> SH) : r_norm[k].m;
                r_norm[k+1].zero <= r_norm[k].zero;
            end
        end
    end

    always_comb begin
        n_rot.x    = 34'(r_norm[qte_pkg::NORM_STEPS].x);
        n_rot.y    = 34'(r_norm[qte_pkg::NORM_STEPS].y);
        n_rot.z    = 32'd0;
        n_rot.zero = r_norm[qte_pkg::NORM_STEPS].zero;
        if (n_rot.x < 34'sd0) begin
            if (n_rot.y >= 34'sd0) begin
                n_rot.x = 34'(r_norm[qte_pkg::NORM_STEPS].y);
                n_rot.y = -34'(r_norm[qte_pkg::NORM_STEPS].x);
                n_rot.z = qte_pkg::QUARTER_POS;
            end else begin
                n_rot.x = -34'(r_norm[qte_pkg::NORM_STEPS].y);
                n_rot.y = 34'(r_norm[qte_pkg::NORM_STEPS].x);
                n_rot.z = qte_pkg::QUARTER_NEG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= n_rot;
        end
    end

    assign chain[0] = r_rot;

    for (genvar i = 0; i < qte_pkg::CORDIC_STAGES; i++) begin : g_cell
        qte_cordic_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_step (5'(i)),
            .i_d    (chain[i]),
            .o_d    (chain[i+1])
        );
    end

    assign o_angle = chain[qte_pkg::CORDIC_STAGES].zero ? 32'd0
                                                        : chain[qte_pkg::CORDIC_STAGES].z;
endmodule

>>> bench/qte_angle_checker.sv
// Checker that predicts yaw, pitch and roll for every quaternion beat and compares results.
`timescale 1ns / 1ps

module qte_angle_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [127:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [47:0]  i_m_tdata,
    output int           o_error_count,
    output int           o_pending
);

    typedef struct packed {
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
    } t_angles;

    localparam logic [31:0] ARCTAN_TURNS [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    t_angles expected_angles[$];

    // Vectoring CORDIC; the angle comes back in units of 2^-32 of a full turn.
    function automatic logic [31:0] atan2_turns(input logic signed [63:0] y_in,
                                                input logic signed [63:0] x_in);
        logic signed [63:0] xv, yv, tmp, dx, dy;
        logic [63:0] mx, my, m;
        logic [31:0] z;
        int sh, n;
        if (x_in == 0 && y_in == 0) return 32'd0;
        mx = (x_in < 0) ? -x_in : x_in;
        my = (y_in < 0) ? -y_in : y_in;
        m  = (mx > my) ? mx : my;
        sh = 0;
        while ((m >> sh) >= (64'd1 << 29)) sh++;
        xv = x_in >>> sh;
        yv = y_in >>> sh;
        z  = 32'd0;
        // Fold the left half plane into the right one by a quarter turn.
        if (xv < 0) begin
            tmp = xv;
            if (yv >= 0) begin
                xv = yv;
                yv = -tmp;
                z  = 32'h4000_0000;
            end else begin
                xv = -yv;
                yv = tmp;
                z  = 32'hC000_0000;
            end
        end
        n = (qte_pkg::CORDIC_STAGES < 24) ? qte_pkg::CORDIC_STAGES : 24;
        for (int i = 0; i < n; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv > 0) begin
                xv = xv + dx;
                yv = yv - dy;
                z  = z + ARCTAN_TURNS[i];
            end else begin
                xv = xv - dx;
                yv = yv + dy;
                z  = z - ARCTAN_TURNS[i];
            end
        end
        return z;
    endfunction

    function automatic logic [63:0] isqrt_u64(input logic [63:0] v_in);
        logic [63:0] v, res, b;
        v   = v_in;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Round to nearest with ties upward, wrapping at a full turn.
    function automatic logic [15:0] turns_to_angle(input logic [31:0] a);
        logic [31:0] r;
        r = (a + (32'd1 << (31 - qte_pkg::ANGLE_BITS))) >> (32 - qte_pkg::ANGLE_BITS);
        return r[15:0];
    endfunction

    function automatic t_angles predict_angles(input logic [127:0] quat);
        logic signed [63:0] w, x, y, z, ww, xx, zz, xy, wz, xz, wy, yz, wx;
        logic signed [63:0] one_q58, s, s30, c;
        t_angles a;
        w = {{32{quat[31]}}, quat[31:0]};
        x = {{32{quat[63]}}, quat[63:32]};
        y = {{32{quat[95]}}, quat[95:64]};
        z = {{32{quat[127]}}, quat[127:96]};
        // Products are exact in Q60 and floor-shifted to Q58.
        ww = (w * w) >>> 2;  xx = (x * x) >>> 2;  zz = (z * z) >>> 2;
        xy = (x * y) >>> 2;  wz = (w * z) >>> 2;
        xz = (x * z) >>> 2;  wy = (w * y) >>> 2;
        yz = (y * z) >>> 2;  wx = (w * x) >>> 2;
        one_q58 = 64'sd1 <<< 58;
        a.yaw = turns_to_angle(atan2_turns(2 * (xy - wz), 2 * (ww + xx) - one_q58));
        // The arcsine argument saturates at plus or minus one.
        s = 2 * (xz + wy);
        if (s > one_q58) s = one_q58;
        if (s < -one_q58) s = -one_q58;
        s30 = s >>> 28;
        c = isqrt_u64((64'd1 << 60) - s30 * s30);
        a.pitch = turns_to_angle(atan2_turns(-s30, c));
        a.roll  = turns_to_angle(atan2_turns(2 * (yz - wx), 2 * (ww + zz) - one_q58));
        return a;
    endfunction

    assign o_pending = expected_angles.size();

    initial o_error_count = 0;

    always @(posedge i_clk) begin
        t_angles want, got;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) expected_angles.push_back(predict_angles(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (expected_angles.size() == 0) begin
                    $error("result beat with no quaternion outstanding: %h", i_m_tdata);
                    o_error_count <= o_error_count + 1;
                end else begin
                    want = expected_angles.pop_front();
                    if (want.yaw !== got.yaw)
                        $error("yaw_angle expected %h actual %h", want.yaw, got.yaw);
                    if (want.pitch !== got.pitch)
                        $error("pitch_angle expected %h actual %h", want.pitch, got.pitch);
                    if (want.roll !== got.roll)
                        $error("roll_angle expected %h actual %h", want.roll, got.roll);
                    if (want !== got) o_error_count <= o_error_count + 1;
                end
            end
        end
    end

endmodule

>>> bench/testbench.sv
// Top of the quaternion to Euler angle bench: clock, reset, beat traffic and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_BEATS  = 2000;
    localparam int QUIET_AFTER   = 1700;   // no idling on either side past this beat
    localparam int HOLD_AT_BEAT  = 600;    // where the receiver takes its long break
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 5000;   // cycles with no beat on either side
    localparam int DRAIN_CYCLES  = qte_pkg::PIPE_LAT + 20;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [127:0] i_s_tdata;   // quat_w, quat_x, quat_y, quat_z
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [47:0]  o_m_tdata;   // yaw_angle, pitch_angle, roll_angle

    int  error_count;
    int  pending;
    int  beats_sent;
    bit  quiet;
    bit  hold_done;
    int  idle_cycles;

    quaternion_to_euler_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    qte_angle_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one quaternion and hold it until the core takes it.
    task automatic send_quat(input logic [31:0] w, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {z, y, x, w};
        do @(posedge i_clk); while (!o_s_tready);
        beats_sent++;
    endtask

    // Sometimes leave a short gap before the next beat.
    task automatic maybe_idle();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // A random attitude scaled to unit length, or up to twice that length so that
    // the arcsine argument lands near or past its clamp.
    task automatic send_unit_quat();
        real c[4];
        real n, scale;
        int  k;
        do begin
            n = 0.0;
            for (k = 0; k < 4; k++) begin
                c[k] = ($itor($urandom_range(0, 2000000)) - 1000000.0) / 1000000.0;
                n = n + c[k] * c[k];
            end
        end while (n < 1.0e-4);
        n = $sqrt(n);
        scale = ($urandom_range(0, 7) == 0) ? 1.0 + $itor($urandom_range(0, 1000)) / 1000.0
                                            : 1.0;
        for (k = 0; k < 4; k++) c[k] = c[k] / n * scale * 1073741824.0;
        send_quat($rtoi(c[0]), $rtoi(c[1]), $rtoi(c[2]), $rtoi(c[3]));
    endtask

    // Receiver: random short stalls, one long hold-off while the sender keeps
    // offering beats so the pipeline fills and back-pressures its input.
    initial begin
        int stall;
        int hold;
        stall = 0;
        hold  = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && beats_sent >= HOLD_AT_BEAT) begin
                hold_done = 1'b1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                i_m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 3) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles in which no beat moves on either side.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int waited;
        beats_sent  = 0;
        quiet       = 1'b0;
        hold_done   = 1'b0;
        idle_cycles = 0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identity, extremes, both atan2 operands zero, clamped pitch.
        send_quat(32'h4000_0000, 32'h0, 32'h0, 32'h0);
        send_quat(32'h0, 32'h0, 32'h0, 32'h0);
        send_quat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_quat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_quat(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_quat(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_quat(32'h2000_0000, 32'h2000_0000, 32'h0, 32'h0);       // yaw operands zero
        send_quat(32'h2000_0000, 32'h0, 32'h0, 32'h2000_0000);       // roll operands zero
        send_quat(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h0);       // arcsine above one
        send_quat(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0);       // arcsine below minus one
        send_quat(32'h2D41_3CCD, 32'h0, 32'h2D41_3CCD, 32'h0);       // pitch near -pi/2
        send_quat(32'h2D41_3CCD, 32'h0, 32'hD2BE_C333, 32'h0);       // pitch near +pi/2
        send_quat(32'h0, 32'h4000_0000, 32'h0, 32'h0);               // half turn about x
        send_quat(32'h0, 32'h0, 32'h0, 32'h4000_0000);               // half turn about z
        send_quat(32'hC000_0000, 32'h0, 32'h0, 32'h0);
        send_quat(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n >= QUIET_AFTER) quiet = 1'b1;
            maybe_idle();
            if ($urandom_range(0, 3) == 0)
                send_quat($urandom, $urandom, $urandom, $urandom);
            else
                send_unit_quat();
        end
        i_s_tvalid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < IDLE_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
